// ===== hdl/dmm_pkg.sv =====
// ----------------------------------------------------------------------------
// dmm_pkg
// shared types, sizes and helpers of the dense matrix multiplier
// ----------------------------------------------------------------------------
package dmm_pkg;

  localparam int unsigned DIM    = 8;
  localparam int unsigned IDX_W  = 3;
  localparam int unsigned SIZE_W = 4;
  localparam int unsigned ELEM_W = 16;
  localparam int unsigned PROD_W = 2 * ELEM_W;
  localparam int unsigned SUM_W  = 36;
  localparam int unsigned FUNC_W = 2;
  localparam int unsigned ADDR_W = $clog2(DIM * DIM);
  localparam int unsigned SLOT_W = 2 * IDX_W + 1;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD_A  = 2'd0,
    FUNC_LOAD_B  = 2'd1,
    FUNC_COMPUTE = 2'd2
  } func_e;

  localparam logic [1:0] REG_ROWS_A    = 2'd0;
  localparam logic [1:0] REG_INNER_DIM = 2'd1;
  localparam logic [1:0] REG_COLS_B    = 2'd2;

  // tag travelling with each multiply-accumulate step
  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             first;
    logic             lastk;
    logic             last;
    logic             zero;
  } tag_t;

  typedef struct packed {
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [SUM_W-1:0] sum;
    logic                    last;
  } res_t;

  function automatic logic [SIZE_W-1:0] eff_size(logic [SIZE_W-1:0] v);
    return (v > SIZE_W'(DIM)) ? SIZE_W'(DIM) : v;
  endfunction

  function automatic logic [ADDR_W-1:0] slot(logic [IDX_W-1:0] r, logic [IDX_W-1:0] c);
    logic [SLOT_W-1:0] s;
    s = SLOT_W'(r) * SLOT_W'(DIM) + SLOT_W'(c);
    return s[ADDR_W-1:0];
  endfunction

endpackage

// ===== hdl/dmm_store.sv =====
// ----------------------------------------------------------------------------
// dmm_store
// element memory, one write port, one registered read port
// ----------------------------------------------------------------------------
module dmm_store (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [dmm_pkg::ADDR_W-1:0]  waddr_i,
  input  logic [dmm_pkg::ELEM_W-1:0]  wdata_i,
  input  logic                        re_i,
  input  logic [dmm_pkg::ADDR_W-1:0]  raddr_i,
  output logic [dmm_pkg::ELEM_W-1:0]  rdata_o
);

  logic [dmm_pkg::ELEM_W-1:0] mem_q [dmm_pkg::DIM * dmm_pkg::DIM];
  logic [dmm_pkg::ELEM_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/dmm_seq.sv =====
// ----------------------------------------------------------------------------
// dmm_seq
// walks row, column and inner index and issues the memory reads
// ----------------------------------------------------------------------------
module dmm_seq (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic                        adv_i,
  input  logic [dmm_pkg::SIZE_W-1:0]  nr_i,
  input  logic [dmm_pkg::SIZE_W-1:0]  nk_i,
  input  logic [dmm_pkg::SIZE_W-1:0]  nc_i,
  output logic                        busy_o,
  output logic                        rd_en_o,
  output logic [dmm_pkg::ADDR_W-1:0]  a_addr_o,
  output logic [dmm_pkg::ADDR_W-1:0]  b_addr_o,
  output logic                        s1_valid_o,
  output dmm_pkg::tag_t               s1_tag_o
);

  logic                       busy_q;
  logic [dmm_pkg::IDX_W-1:0]  i_q, j_q, k_q;
  logic                       s1_valid_q;
  dmm_pkg::tag_t              s1_tag_q, tag_d;
  logic [dmm_pkg::SIZE_W-1:0] kmax;
  logic                       lastk, lastj, lasti, issue;

  assign kmax  = (nk_i == '0) ? '0 : nk_i - 1'b1;
  assign lastk = {1'b0, k_q} == kmax;
  assign lastj = {1'b0, j_q} == nc_i - 1'b1;
  assign lasti = {1'b0, i_q} == nr_i - 1'b1;
  assign issue = busy_q & adv_i;

  always_comb begin
    tag_d       = '0;
    tag_d.row   = i_q;
    tag_d.col   = j_q;
    tag_d.first = (k_q == '0);
    tag_d.lastk = lastk;
    tag_d.last  = lastk & lastj & lasti;
    tag_d.zero  = (nk_i == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      i_q    <= '0;
      j_q    <= '0;
      k_q    <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      i_q    <= '0;
      j_q    <= '0;
      k_q    <= '0;
    end else if (issue) begin
      if (!lastk) begin
        k_q <= k_q + 1'b1;
      end else begin
        k_q <= '0;
        if (!lastj) begin
          j_q <= j_q + 1'b1;
        end else begin
          j_q <= '0;
          if (lasti) begin
            busy_q <= 1'b0;
          end else begin
            i_q <= i_q + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv_i) begin
      s1_valid_q <= busy_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s1_tag_q <= tag_d;
    end
  end

  assign busy_o     = busy_q;
  assign rd_en_o    = issue;
  assign a_addr_o   = dmm_pkg::slot(i_q, k_q);
  assign b_addr_o   = dmm_pkg::slot(k_q, j_q);
  assign s1_valid_o = s1_valid_q;
  assign s1_tag_o   = s1_tag_q;

endmodule

// ===== hdl/dmm_mac.sv =====
// ----------------------------------------------------------------------------
// dmm_mac
// registered multiply followed by the accumulator
// ----------------------------------------------------------------------------
module dmm_mac (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        adv_i,
  input  logic                        s1_valid_i,
  input  dmm_pkg::tag_t               s1_tag_i,
  input  logic [dmm_pkg::ELEM_W-1:0]  a_i,
  input  logic [dmm_pkg::ELEM_W-1:0]  b_i,
  output logic                        busy_o,
  output logic                        res_valid_o,
  output dmm_pkg::res_t               res_o
);

  logic                               s2_valid_q;
  dmm_pkg::tag_t                      s2_tag_q;
  logic signed [dmm_pkg::PROD_W-1:0]  mult, prod_d, prod_q;
  logic signed [dmm_pkg::SUM_W-1:0]   acc_q, acc_d;

  assign mult   = $signed(a_i) * $signed(b_i);
  assign prod_d = s1_tag_i.zero ? '0 : mult;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (adv_i) begin
      s2_valid_q <= s1_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s2_tag_q <= s1_tag_i;
      prod_q   <= prod_d;
    end
  end

  assign acc_d = (s2_tag_q.first ? '0 : acc_q) + dmm_pkg::SUM_W'(prod_q);

  always_ff @(posedge clk_i) begin
    if (adv_i && s2_valid_q) begin
      acc_q <= acc_d;
    end
  end

  assign busy_o      = s2_valid_q;
  assign res_valid_o = s2_valid_q & s2_tag_q.lastk;

  always_comb begin
    res_o      = '0;
    res_o.row  = s2_tag_q.row;
    res_o.col  = s2_tag_q.col;
    res_o.sum  = acc_d;
    res_o.last = s2_tag_q.last;
  end

endmodule

// ===== hdl/dense_matrix_multiply.sv =====
// ----------------------------------------------------------------------------
// dense_matrix_multiply
// fixed-point matrix product of two stored matrices, streamed out per element
// ----------------------------------------------------------------------------
// load items: one per cycle while no compute item is in progress, no result
// compute item: R*C*max(K,1) multiply-accumulate steps, one per cycle unless the
//   output stalls, set by the single read port of each element memory; each
//   sum is formed from the memory read and product registers and the accumulator
//   and held in the output register; a new item is taken once the last result sits in the output
// reset: sizes return to 8, pipeline and output emptied, memories not cleared
// ----------------------------------------------------------------------------
module dense_matrix_multiply (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // row_index, col_index, element
  input  logic [1:0]  s_axis_tuser,   // func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // out_row, out_col, sum
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned OUT_PAD_W = 48 - (2 * dmm_pkg::IDX_W + dmm_pkg::SUM_W);

  logic [dmm_pkg::SIZE_W-1:0] rows_a_q, inner_dim_q, cols_b_q;
  logic [dmm_pkg::SIZE_W-1:0] nr, nk, nc;
  logic                       cfg_wr;
  logic [dmm_pkg::IDX_W-1:0]  in_row, in_col;
  logic [dmm_pkg::ELEM_W-1:0] in_elem;
  logic                       in_acc, we_a, we_b, start;
  logic                       adv, seq_busy, rd_en, s1_valid, mac_busy, res_valid;
  logic [dmm_pkg::ADDR_W-1:0] a_raddr, b_raddr, waddr;
  logic [dmm_pkg::ELEM_W-1:0] a_rdata, b_rdata;
  dmm_pkg::tag_t              s1_tag;
  dmm_pkg::res_t              res, out_q;
  logic                       out_valid_q;

  // configuration
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_a_q    <= dmm_pkg::SIZE_RESET;
      inner_dim_q <= dmm_pkg::SIZE_RESET;
      cols_b_q    <= dmm_pkg::SIZE_RESET;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        dmm_pkg::REG_ROWS_A:    rows_a_q    <= pwdata[dmm_pkg::SIZE_W-1:0];
        dmm_pkg::REG_INNER_DIM: inner_dim_q <= pwdata[dmm_pkg::SIZE_W-1:0];
        dmm_pkg::REG_COLS_B:    cols_b_q    <= pwdata[dmm_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      dmm_pkg::REG_ROWS_A:    prdata = 32'(rows_a_q);
      dmm_pkg::REG_INNER_DIM: prdata = 32'(inner_dim_q);
      dmm_pkg::REG_COLS_B:    prdata = 32'(cols_b_q);
      default:                prdata = '0;
    endcase
  end

  assign nr = dmm_pkg::eff_size(rows_a_q);
  assign nk = dmm_pkg::eff_size(inner_dim_q);
  assign nc = dmm_pkg::eff_size(cols_b_q);

  // input side
  assign in_row  = s_axis_tdata[2:0];
  assign in_col  = s_axis_tdata[5:3];
  assign in_elem = s_axis_tdata[21:6];

  assign s_axis_tready = ~seq_busy & ~s1_valid & ~mac_busy;
  assign in_acc        = s_axis_tvalid & s_axis_tready;

  assign we_a  = in_acc && (s_axis_tuser == dmm_pkg::FUNC_LOAD_A)
                 && ({1'b0, in_row} < nr) && ({1'b0, in_col} < nk);
  assign we_b  = in_acc && (s_axis_tuser == dmm_pkg::FUNC_LOAD_B)
                 && ({1'b0, in_row} < nk) && ({1'b0, in_col} < nc);
  assign start = in_acc && (s_axis_tuser == dmm_pkg::FUNC_COMPUTE)
                 && (nr != '0) && (nc != '0);
  assign waddr = dmm_pkg::slot(in_row, in_col);

  // whole pipeline moves unless a waiting result is held up
  assign adv = ~out_valid_q | m_axis_tready;

  dmm_store u_a_store (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (waddr),
    .wdata_i (in_elem),
    .re_i    (rd_en),
    .raddr_i (a_raddr),
    .rdata_o (a_rdata)
  );

  dmm_store u_b_store (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (waddr),
    .wdata_i (in_elem),
    .re_i    (rd_en),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  dmm_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .adv_i      (adv),
    .nr_i       (nr),
    .nk_i       (nk),
    .nc_i       (nc),
    .busy_o     (seq_busy),
    .rd_en_o    (rd_en),
    .a_addr_o   (a_raddr),
    .b_addr_o   (b_raddr),
    .s1_valid_o (s1_valid),
    .s1_tag_o   (s1_tag)
  );

  dmm_mac u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .s1_valid_i  (s1_valid),
    .s1_tag_i    (s1_tag),
    .a_i         (a_rdata),
    .b_i         (b_rdata),
    .busy_o      (mac_busy),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_q.sum, out_q.col, out_q.row};
  assign m_axis_tlast  = out_q.last;

endmodule

// ===== hdl/dmm_checker.sv =====
// ----------------------------------------------------------------------------
// dmm_checker
// port-level checks of the matrix multiplier, bound to the top level
// ----------------------------------------------------------------------------
module dmm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [23:0] s_axis_tdata,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [3:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready
);

  logic in_acc;

  assign in_acc = s_axis_tvalid & s_axis_tready;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // a load never produces a result
  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (s_axis_tuser != dmm_pkg::FUNC_COMPUTE) && !m_axis_tvalid |=>
      !m_axis_tvalid)
    else $error("result after a load item");

  // a new result only comes out of a busy pipeline
  a_out_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result while input side was idle");

  // input side closed while results of a run are still being formed
  a_no_accept_mid_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |-> !s_axis_tready)
    else $error("item accepted in the middle of a run");

endmodule

bind dense_matrix_multiply dmm_checker u_dmm_checker (.*);

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the dense matrix multiplier
// ----------------------------------------------------------------------------
// operand items are streamed in and mirrored into a local copy of both
// matrices; each compute item predicts every element of the product, which
// is matched in order against the output stream. sizes are set over apb
// between phases. a directed part covers extreme values and degenerate
// sizes, then a long output stall, then random load-and-multiply sequences
// with noise, under random input gaps and output stalls
// ----------------------------------------------------------------------------
module tb;

  localparam logic [dmm_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 260;
  localparam int DRAIN_CYCLES = 32;
  localparam int LONG_STALL   = 400;
  localparam int STALL_LIMIT  = 4000;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;   // row_index, col_index, element
  logic [1:0]  s_axis_tuser;   // func
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;   // out_row, out_col, sum
  logic        m_axis_tlast;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // local copy of the operand matrices and sizes
  logic signed [dmm_pkg::ELEM_W-1:0] a_mat [dmm_pkg::DIM][dmm_pkg::DIM];
  logic signed [dmm_pkg::ELEM_W-1:0] b_mat [dmm_pkg::DIM][dmm_pkg::DIM];
  bit                                a_set [dmm_pkg::DIM][dmm_pkg::DIM];
  bit                                b_set [dmm_pkg::DIM][dmm_pkg::DIM];
  logic [dmm_pkg::SIZE_W-1:0]        rows_cfg;
  logic [dmm_pkg::SIZE_W-1:0]        inner_cfg;
  logic [dmm_pkg::SIZE_W-1:0]        cols_cfg;

  dmm_pkg::res_t expected_products[$];
  int            mismatches;
  int            useful_items;
  int            burst_left;
  bit            long_stall_req;

  dense_matrix_multiply i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int clip_size(logic [dmm_pkg::SIZE_W-1:0] v);
    return (v > dmm_pkg::DIM) ? int'(dmm_pkg::DIM) : int'(v);
  endfunction

  function automatic bit operands_ready();
    int nr, nk, nc;
    nr = clip_size(rows_cfg);
    nk = clip_size(inner_cfg);
    nc = clip_size(cols_cfg);
    for (int i = 0; i < nr; i++)
      for (int k = 0; k < nk; k++)
        if (!a_set[i][k]) return 1'b0;
    for (int k = 0; k < nk; k++)
      for (int j = 0; j < nc; j++)
        if (!b_set[k][j]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void predict_products(logic [dmm_pkg::FUNC_W-1:0] func,
                                           logic [dmm_pkg::IDX_W-1:0] r,
                                           logic [dmm_pkg::IDX_W-1:0] c,
                                           logic signed [dmm_pkg::ELEM_W-1:0] elem);
    int            nr, nk, nc;
    longint        acc;
    dmm_pkg::res_t prod;
    nr = clip_size(rows_cfg);
    nk = clip_size(inner_cfg);
    nc = clip_size(cols_cfg);
    case (func)
      dmm_pkg::FUNC_LOAD_A: begin
        if (r < nr && c < nk) begin
          a_mat[r][c] = elem;
          a_set[r][c] = 1'b1;
          useful_items++;
        end
      end
      dmm_pkg::FUNC_LOAD_B: begin
        if (r < nk && c < nc) begin
          b_mat[r][c] = elem;
          b_set[r][c] = 1'b1;
          useful_items++;
        end
      end
      dmm_pkg::FUNC_COMPUTE: begin
        useful_items++;
        for (int i = 0; i < nr; i++) begin
          for (int j = 0; j < nc; j++) begin
            acc = 0;
            for (int k = 0; k < nk; k++)
              acc += longint'(a_mat[i][k]) * longint'(b_mat[k][j]);
            prod.row  = dmm_pkg::IDX_W'(i);
            prod.col  = dmm_pkg::IDX_W'(j);
            prod.sum  = acc[dmm_pkg::SUM_W-1:0];
            prod.last = (i == nr - 1) && (j == nc - 1);
            expected_products = {expected_products, prod};
          end
        end
      end
      default: ;
    endcase
  endfunction

  task automatic send_item(logic [dmm_pkg::FUNC_W-1:0] func, logic [dmm_pkg::IDX_W-1:0] r,
                           logic [dmm_pkg::IDX_W-1:0] c, logic [dmm_pkg::ELEM_W-1:0] elem);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 16);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= {2'b00, elem, c, r};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_products(func, r, c, $signed(elem));
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_products.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [dmm_pkg::SIZE_W-1:0] size);
    logic [27:0] junk;
    junk = ($urandom_range(0, 1) != 0) ? 28'($urandom) : 28'd0;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {junk, size};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      dmm_pkg::REG_ROWS_A:    rows_cfg  = size;
      dmm_pkg::REG_INNER_DIM: inner_cfg = size;
      dmm_pkg::REG_COLS_B:    cols_cfg  = size;
      default: ;
    endcase
  endtask

  task automatic configure(logic [dmm_pkg::SIZE_W-1:0] rows,
                           logic [dmm_pkg::SIZE_W-1:0] inner,
                           logic [dmm_pkg::SIZE_W-1:0] cols);
    wait_idle();
    write_reg(dmm_pkg::REG_ROWS_A, rows);
    write_reg(dmm_pkg::REG_INNER_DIM, inner);
    write_reg(dmm_pkg::REG_COLS_B, cols);
  endtask

  task automatic send_noise();
    logic [dmm_pkg::FUNC_W-1:0] func;
    func = dmm_pkg::FUNC_W'($urandom_range(0, 3));
    if (func == dmm_pkg::FUNC_COMPUTE && !operands_ready()) func = FUNC_UNUSED;
    send_item(func, dmm_pkg::IDX_W'($urandom), dmm_pkg::IDX_W'($urandom),
              dmm_pkg::ELEM_W'($urandom));
  endtask

  // load operands (unwritten ones plus a random part); multiply, or stop after A
  task automatic run_product_sequence(bit allow_broken);
    int nr, nk, nc;
    nr = clip_size(rows_cfg);
    nk = clip_size(inner_cfg);
    nc = clip_size(cols_cfg);
    for (int i = 0; i < nr; i++)
      for (int k = 0; k < nk; k++) begin
        if (!a_set[i][k] || $urandom_range(0, 1) != 0)
          send_item(dmm_pkg::FUNC_LOAD_A, dmm_pkg::IDX_W'(i), dmm_pkg::IDX_W'(k),
                    dmm_pkg::ELEM_W'($urandom));
        if ($urandom_range(0, 15) == 0) send_noise();
      end
    if (allow_broken && $urandom_range(0, 7) == 0) return;
    for (int k = 0; k < nk; k++)
      for (int j = 0; j < nc; j++) begin
        if (!b_set[k][j] || $urandom_range(0, 1) != 0)
          send_item(dmm_pkg::FUNC_LOAD_B, dmm_pkg::IDX_W'(k), dmm_pkg::IDX_W'(j),
                    dmm_pkg::ELEM_W'($urandom));
        if ($urandom_range(0, 15) == 0) send_noise();
      end
    send_item(dmm_pkg::FUNC_COMPUTE, dmm_pkg::IDX_W'($urandom), dmm_pkg::IDX_W'($urandom),
              dmm_pkg::ELEM_W'($urandom));
  endtask

  function automatic logic [dmm_pkg::SIZE_W-1:0] pick_size();
    int roll;
    roll = $urandom_range(0, 19);
    if (roll == 0) return 4'd0;
    if (roll == 1) return 4'd8;
    if (roll == 2) return dmm_pkg::SIZE_W'($urandom_range(9, 15));
    return dmm_pkg::SIZE_W'($urandom_range(1, 4));
  endfunction

  task automatic test_extreme_values();
    send_item(dmm_pkg::FUNC_LOAD_A, 3'd7, 3'd7, 16'h7fff);
    send_item(dmm_pkg::FUNC_LOAD_B, 3'd7, 3'd7, 16'h8000);
    configure(4'd2, 4'd2, 4'd2);
    send_item(dmm_pkg::FUNC_LOAD_A, 3'd0, 3'd0, 16'h8000);
    send_item(dmm_pkg::FUNC_LOAD_A, 3'd0, 3'd1, 16'h8000);
    send_item(dmm_pkg::FUNC_LOAD_A, 3'd1, 3'd0, 16'h7fff);
    send_item(dmm_pkg::FUNC_LOAD_A, 3'd1, 3'd1, 16'h0001);
    send_item(dmm_pkg::FUNC_LOAD_B, 3'd0, 3'd0, 16'h8000);
    send_item(dmm_pkg::FUNC_LOAD_B, 3'd0, 3'd1, 16'h7fff);
    send_item(dmm_pkg::FUNC_LOAD_B, 3'd1, 3'd0, 16'h8000);
    send_item(dmm_pkg::FUNC_LOAD_B, 3'd1, 3'd1, 16'hffff);
    // out of range loads
    send_item(dmm_pkg::FUNC_LOAD_A, 3'd2, 3'd0, 16'h1234);
    send_item(dmm_pkg::FUNC_LOAD_A, 3'd0, 3'd7, 16'h1234);
    send_item(dmm_pkg::FUNC_LOAD_B, 3'd7, 3'd0, 16'h1234);
    send_item(dmm_pkg::FUNC_LOAD_B, 3'd1, 3'd2, 16'h1234);
    send_item(FUNC_UNUSED, 3'd7, 3'd7, 16'hffff);
    send_item(dmm_pkg::FUNC_COMPUTE, 3'd0, 3'd0, 16'h0000);
  endtask

  task automatic test_degenerate_sizes();
    configure(4'd2, 4'd0, 4'd2);
    send_item(dmm_pkg::FUNC_COMPUTE, 3'd0, 3'd0, 16'h0000);
    configure(4'd0, 4'd2, 4'd2);
    send_item(dmm_pkg::FUNC_LOAD_A, 3'd0, 3'd0, 16'h4321);
    send_item(dmm_pkg::FUNC_COMPUTE, 3'd0, 3'd0, 16'h0000);
    // row-vector times column-vector product
    configure(4'd1, 4'd2, 4'd1);
    send_item(dmm_pkg::FUNC_COMPUTE, 3'd0, 3'd0, 16'h0000);
    configure(4'd1, 4'd2, 4'd0);
    send_item(dmm_pkg::FUNC_LOAD_B, 3'd0, 3'd0, 16'h4321);
    send_item(dmm_pkg::FUNC_COMPUTE, 3'd0, 3'd0, 16'h0000);
  endtask

  task automatic test_output_backpressure();
    configure(4'd4, 4'd3, 4'd4);
    long_stall_req = 1'b1;
    run_product_sequence(1'b0);
    run_product_sequence(1'b0);
  endtask

  task automatic test_random_products();
    int phase, start;
    phase = 0;
    start = useful_items;
    while (useful_items - start < RANDOM_ITEMS) begin
      if (phase == 0) configure(4'd15, 4'd8, 4'd9);
      else if (phase == 1) configure(4'd1, 4'd1, 4'd1);
      else configure(pick_size(), pick_size(), pick_size());
      repeat ($urandom_range(1, 3)) run_product_sequence(1'b1);
      phase++;
    end
  endtask

  // output side stalls
  initial begin : result_sink
    int rx_mode, phase_cnt;
    rx_mode   = 0;
    phase_cnt = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_stall_req) begin
        m_axis_tready <= 1'b0;
        repeat (LONG_STALL) @(posedge clk_i);
        long_stall_req = 1'b0;
      end else begin
        if (phase_cnt == 0) begin
          rx_mode   = $urandom_range(0, 3);
          phase_cnt = $urandom_range(16, 96);
        end
        phase_cnt--;
        case (rx_mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= ($urandom_range(0, 1) != 0);
          2: m_axis_tready <= ((phase_cnt % 4) == 0);
          default: m_axis_tready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    dmm_pkg::res_t                    want;
    logic [dmm_pkg::IDX_W-1:0]        got_row;
    logic [dmm_pkg::IDX_W-1:0]        got_col;
    logic signed [dmm_pkg::SUM_W-1:0] got_sum;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_row = m_axis_tdata[2:0];
      got_col = m_axis_tdata[5:3];
      got_sum = m_axis_tdata[6 +: dmm_pkg::SUM_W];
      if (expected_products.size() == 0) begin
        $display("%0t: unexpected result row %0d col %0d sum %0d", $time, got_row,
                 got_col, got_sum);
        mismatches++;
      end else begin
        want = expected_products.pop_front();
        if (got_row !== want.row) begin
          $display("%0t: out_row mismatch, expected %0d, got %0d", $time, want.row, got_row);
          mismatches++;
        end
        if (got_col !== want.col) begin
          $display("%0t: out_col mismatch, expected %0d, got %0d", $time, want.col, got_col);
          mismatches++;
        end
        if (got_sum !== want.sum) begin
          $display("%0t: sum mismatch at (%0d,%0d), expected %0d, got %0d", $time, want.row,
                   want.col, want.sum, got_sum);
          mismatches++;
        end
        if (m_axis_tlast !== want.last) begin
          $display("%0t: last mismatch at (%0d,%0d), expected %0b, got %0b", $time, want.row,
                   want.col, want.last, m_axis_tlast);
          mismatches++;
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (psel && penable))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: no handshake for %0d cycles", $time, quiet);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    rst_ni         <= 1'b0;
    s_axis_tvalid  <= 1'b0;
    s_axis_tdata   <= '0;
    s_axis_tuser   <= '0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    rows_cfg       = dmm_pkg::SIZE_RESET;
    inner_cfg      = dmm_pkg::SIZE_RESET;
    cols_cfg       = dmm_pkg::SIZE_RESET;
    mismatches     = 0;
    useful_items   = 0;
    burst_left     = 0;
    long_stall_req = 1'b0;
    for (int i = 0; i < dmm_pkg::DIM; i++)
      for (int j = 0; j < dmm_pkg::DIM; j++) begin
        a_mat[i][j] = '0;
        b_mat[i][j] = '0;
        a_set[i][j] = 1'b0;
        b_set[i][j] = 1'b0;
      end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_extreme_values();
    test_degenerate_sizes();
    test_output_backpressure();
    test_random_products();
    wait_idle();

    if (mismatches == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/dmm_pkg.sv
hdl/dmm_store.sv
hdl/dmm_seq.sv
hdl/dmm_mac.sv
hdl/dense_matrix_multiply.sv
hdl/dmm_checker.sv
tb/tb.sv
